// ===== design/rbps_pkg.sv =====
`timescale 1ns / 1ps

package rbps_pkg;

   // field and register widths
   localparam int PIXEL_W = 32;
   localparam int CHAN_W  = 8;
   localparam int POS_W   = 13;
   localparam int OUT_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int TURN_W  = 2;
   localparam int BRIGHT_W = 9;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam int DEFAULT_MAX_DIM     = 4096;
   localparam int DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // register indexes
   localparam logic [2:0] REG_QUARTER_TURNS = 3'd0;
   localparam logic [2:0] REG_BRIGHTNESS    = 3'd1;
   localparam logic [2:0] REG_REGION_COLS   = 3'd2;
   localparam logic [2:0] REG_REGION_ROWS   = 3'd3;
   localparam logic [2:0] REG_START_X       = 3'd4;
   localparam logic [2:0] REG_START_Y       = 3'd5;

   // one queued pixel, classified by the front end
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [OUT_W-1:0]   dest_x;
      logic [OUT_W-1:0]   dest_y;
      logic               last;
   } rbps_entry_type;

   // geometry settings shared by the front end
   typedef struct packed {
      logic [TURN_W-1:0] turns;
      logic [SIZE_W-1:0] cols;
      logic [SIZE_W-1:0] rows;
      logic [OUT_W-1:0]  start_x;
      logic [OUT_W-1:0]  start_y;
      logic              restart;
   } rbps_geom_type;

   typedef struct packed {
      logic [POS_W-1:0] pix_dx;
      logic [POS_W-1:0] pix_dy;
      logic [POS_W-1:0] row_dx;
      logic [POS_W-1:0] row_dy;
   } rbps_step_type;

   localparam logic [POS_W-1:0] STEP_ZERO = '0;
   localparam logic [POS_W-1:0] STEP_PLUS = POS_W'(1);
   localparam logic [POS_W-1:0] STEP_MINUS = '1;

   // position steps per quarter-turn count, 13-bit two's complement
   function automatic rbps_step_type turn_steps(input logic [TURN_W-1:0] turns);
      rbps_step_type s;
      case (turns)
         2'd0: s = '{STEP_PLUS,  STEP_ZERO,  STEP_ZERO,  STEP_PLUS};
         2'd1: s = '{STEP_ZERO,  STEP_PLUS,  STEP_MINUS, STEP_ZERO};
         2'd2: s = '{STEP_MINUS, STEP_ZERO,  STEP_ZERO,  STEP_MINUS};
         2'd3: s = '{STEP_ZERO,  STEP_MINUS, STEP_PLUS,  STEP_ZERO};
         default: s = '{STEP_PLUS, STEP_ZERO, STEP_ZERO, STEP_PLUS};
      endcase
      return s;
   endfunction

endpackage

// ===== design/rotate_brightness_pixel_stream_top.sv =====
`timescale 1ns / 1ps

// Quarter-turn rotation with brightness offset. Pixels of a source region arrive in
// raster order as ARGB words; each response carries the pixel with the offset added
// to red, green and blue (clamped to 0..255, alpha untouched) and its destination
// column and row in the image turned by 0..3 clockwise quarter turns, plus a flag on
// the region's final pixel. The block takes one request per clock and returns one
// response per clock when nothing stalls; a request is written into the queue and
// then popped into the output register that drives the response ports. The front
// end walks the destination position with column and row counters, a queue of
// QUEUE_DEPTH entries (four by default) decouples it from the back end that does
// the channel clamps into an output register, so a stalled response does not
// stop requests until the queue fills. Registers sit at byte address 4*index:
// quarter_turns, brightness, region_cols, region_rows, start_x, start_y. Writing
// any register but brightness restarts the frame at the start corner, using the
// value just written. Write registers only while the block is idle.

module rotate_brightness_pixel_stream_top
   import rbps_pkg::*;
#(
   parameter int MAX_DIM     = DEFAULT_MAX_DIM,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PIXEL_W-1:0]  req_pixel_in,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_dest_x,
   output logic [OUT_W-1:0]    rsp_dest_y,
   output logic [PIXEL_W-1:0]  rsp_pixel_out,
   output logic                rsp_frame_last,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [DATA_W-1:0]   csr_pwdata,
   output logic [DATA_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   // configuration registers
   logic [TURN_W-1:0]          turns_ff;
   logic signed [BRIGHT_W-1:0] bright_ff;
   logic [SIZE_W-1:0]          cols_ff;
   logic [SIZE_W-1:0]          rows_ff;
   logic [OUT_W-1:0]           start_x_ff, start_x_in;
   logic [OUT_W-1:0]           start_y_ff, start_y_in;

   logic                       csr_we;
   logic [2:0]                 csr_index;
   logic                       geom_write;
   rbps_geom_type              geom;

   // front to queue to back
   logic                       push;
   rbps_entry_type             push_entry;
   logic                       queue_full;
   logic                       queue_not_empty;
   rbps_entry_type             head;
   logic                       pop;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // any geometry register write restarts the frame walk
   always_comb begin
      geom_write = csr_we && (csr_index inside {REG_QUARTER_TURNS, REG_REGION_COLS,
                                                REG_REGION_ROWS, REG_START_X,
                                                REG_START_Y});
   end

   // start corner as it stands after this edge, so a restart lands on a new corner
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (csr_we && csr_index == REG_START_X) begin
         start_x_in = csr_pwdata[OUT_W-1:0];
      end
      if (csr_we && csr_index == REG_START_Y) begin
         start_y_in = csr_pwdata[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turns_ff   <= '0;
         bright_ff  <= '0;
         cols_ff    <= SIZE_W'(1);
         rows_ff    <= SIZE_W'(1);
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_QUARTER_TURNS: turns_ff   <= csr_pwdata[TURN_W-1:0];
            REG_BRIGHTNESS:    bright_ff  <= csr_pwdata[BRIGHT_W-1:0];
            REG_REGION_COLS:   cols_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_REGION_ROWS:   rows_ff    <= csr_pwdata[SIZE_W-1:0];
            REG_START_X:       start_x_ff <= start_x_in;
            REG_START_Y:       start_y_ff <= start_y_in;
            default: ;
         endcase
      end
   end

   // register readback, unused addresses read zero
   always_comb begin
      case (csr_index)
         REG_QUARTER_TURNS: csr_prdata = DATA_W'(turns_ff);
         REG_BRIGHTNESS:    csr_prdata = DATA_W'(unsigned'(bright_ff));
         REG_REGION_COLS:   csr_prdata = DATA_W'(cols_ff);
         REG_REGION_ROWS:   csr_prdata = DATA_W'(rows_ff);
         REG_START_X:       csr_prdata = DATA_W'(start_x_ff);
         REG_START_Y:       csr_prdata = DATA_W'(start_y_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      geom.turns   = turns_ff;
      geom.cols    = cols_ff;
      geom.rows    = rows_ff;
      geom.start_x = start_x_in;
      geom.start_y = start_y_in;
      geom.restart = geom_write;
   end

   // front end: position walk and region counters
   rbps_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .in_valid   (req_valid),
      .in_pixel   (req_pixel_in),
      .queue_full (queue_full),
      .in_stall   (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   // short queue between the two halves
   rbps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // back end: brightness clamp and response register
   rbps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .brightness      (bright_ff),
      .queue_not_empty (queue_not_empty),
      .head            (head),
      .pop             (pop),
      .out_stall       (rsp_stall),
      .out_valid       (rsp_valid),
      .out_dest_x      (rsp_dest_x),
      .out_dest_y      (rsp_dest_y),
      .out_pixel       (rsp_pixel_out),
      .out_last        (rsp_frame_last)
   );

endmodule

// ===== design/rbps_front.sv =====
`timescale 1ns / 1ps

module rbps_front
   import rbps_pkg::*;
#(
   parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
   input  logic                clock,
   input  logic                reset,
   input  rbps_geom_type       geom,
   input  logic                in_valid,
   input  logic [PIXEL_W-1:0]  in_pixel,
   input  logic                queue_full,
   output logic                in_stall,
   output logic                push,
   output rbps_entry_type      push_entry
);

   localparam int CNT_W = ($clog2(MAX_DIM) < SIZE_W) ? $clog2(MAX_DIM) : SIZE_W;

   logic [CNT_W-1:0] col_cnt_ff, col_cnt_in;
   logic [CNT_W-1:0] row_cnt_ff, row_cnt_in;
   logic [POS_W-1:0] pos_x_ff, pos_x_in;
   logic [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [POS_W-1:0] rs_x_ff, rs_x_in;
   logic [POS_W-1:0] rs_y_ff, rs_y_in;

   logic [SIZE_W-1:0] cols_eff, rows_eff;
   logic [SIZE_W-1:0] last_col, last_row;
   logic              row_end, frame_end;
   rbps_step_type     st;
   logic [POS_W-1:0]  start_x_pos, start_y_pos;
   logic [POS_W-1:0]  next_rs_x, next_rs_y;

   // effective region size: zero acts as one, clamp to the maximum
   always_comb begin
      if (geom.cols == '0) begin
         cols_eff = SIZE_W'(1);
      end else if (32'(geom.cols) > MAX_DIM) begin
         cols_eff = SIZE_W'(MAX_DIM);
      end else begin
         cols_eff = geom.cols;
      end
      if (geom.rows == '0) begin
         rows_eff = SIZE_W'(1);
      end else if (32'(geom.rows) > MAX_DIM) begin
         rows_eff = SIZE_W'(MAX_DIM);
      end else begin
         rows_eff = geom.rows;
      end
   end

   assign last_col    = cols_eff - SIZE_W'(1);
   assign last_row    = rows_eff - SIZE_W'(1);
   assign row_end     = SIZE_W'(col_cnt_ff) == last_col;
   assign frame_end   = row_end && (SIZE_W'(row_cnt_ff) == last_row);
   assign st          = turn_steps(geom.turns);
   assign start_x_pos = POS_W'(geom.start_x);
   assign start_y_pos = POS_W'(geom.start_y);
   assign next_rs_x   = rs_x_ff + st.row_dx;
   assign next_rs_y   = rs_y_ff + st.row_dy;

   assign in_stall = queue_full;
   assign push     = in_valid && !queue_full;

   always_comb begin
      push_entry.pixel  = in_pixel;
      push_entry.dest_x = pos_x_ff[OUT_W-1:0];
      push_entry.dest_y = pos_y_ff[OUT_W-1:0];
      push_entry.last   = frame_end;
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      rs_x_in    = rs_x_ff;
      rs_y_in    = rs_y_ff;
      if (geom.restart || (push && frame_end)) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
         pos_x_in   = start_x_pos;
         pos_y_in   = start_y_pos;
         rs_x_in    = start_x_pos;
         rs_y_in    = start_y_pos;
      end else if (push && row_end) begin
         col_cnt_in = '0;
         row_cnt_in = row_cnt_ff + CNT_W'(1);
         rs_x_in    = next_rs_x;
         rs_y_in    = next_rs_y;
         pos_x_in   = next_rs_x;
         pos_y_in   = next_rs_y;
      end else if (push) begin
         col_cnt_in = col_cnt_ff + CNT_W'(1);
         pos_x_in   = pos_x_ff + st.pix_dx;
         pos_y_in   = pos_y_ff + st.pix_dy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         rs_x_ff    <= '0;
         rs_y_ff    <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         rs_x_ff    <= rs_x_in;
         rs_y_ff    <= rs_y_in;
      end
   end

   // the frame's last pixel sends the walk back to the start corner
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (push && frame_end && !geom.restart) |=>
         (col_cnt_ff == '0 && row_cnt_ff == '0 && pos_x_ff == rs_x_ff))
      else $error("position walk did not return to the start corner");

   // a row step lands the pixel position on the new row start
   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (push && row_end && !frame_end && !geom.restart) |=>
         (col_cnt_ff == '0 && pos_x_ff == rs_x_ff && pos_y_ff == rs_y_ff))
      else $error("row step left the position off the row start");

endmodule

// ===== design/rbps_queue.sv =====
`timescale 1ns / 1ps

module rbps_queue
   import rbps_pkg::*;
#(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rbps_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output rbps_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rbps_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

// ===== design/rbps_back.sv =====
`timescale 1ns / 1ps

module rbps_back
   import rbps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [BRIGHT_W-1:0] brightness,
   input  logic                       queue_not_empty,
   input  rbps_entry_type             head,
   output logic                       pop,
   input  logic                       out_stall,
   output logic                       out_valid,
   output logic [OUT_W-1:0]           out_dest_x,
   output logic [OUT_W-1:0]           out_dest_y,
   output logic [PIXEL_W-1:0]         out_pixel,
   output logic                       out_last
);

   logic                 valid_ff, valid_in;
   logic [OUT_W-1:0]     dest_x_ff;
   logic [OUT_W-1:0]     dest_y_ff;
   logic [PIXEL_W-1:0]   pixel_ff, pixel_in;
   logic                 last_ff;

   // channel plus offset, clamped to 0..255
   function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] chan,
                                                    input logic signed [BRIGHT_W-1:0] off);
      logic signed [CHAN_W+2:0] sum;
      sum = $signed({3'b000, chan}) + (CHAN_W+3)'(off);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed((CHAN_W+3)'(CHAN_MAX))) begin
         return CHAN_MAX;
      end else begin
         return sum[CHAN_W-1:0];
      end
   endfunction

   assign pop = queue_not_empty && (!valid_ff || !out_stall);

   always_comb begin
      pixel_in[31:24] = head.pixel[31:24];
      pixel_in[23:16] = clamp_chan(head.pixel[23:16], brightness);
      pixel_in[15:8]  = clamp_chan(head.pixel[15:8], brightness);
      pixel_in[7:0]   = clamp_chan(head.pixel[7:0], brightness);
   end

   always_comb begin
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         dest_x_ff <= head.dest_x;
         dest_y_ff <= head.dest_y;
         pixel_ff  <= pixel_in;
         last_ff   <= head.last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_dest_x = dest_x_ff;
   assign out_dest_y = dest_y_ff;
   assign out_pixel  = pixel_ff;
   assign out_last   = last_ff;

endmodule
